@@ design/binary_to_decimal_ascii_defines.svh @@
// assertion macros for the binary to decimal ascii converter
// no dependencies; included by the top level only
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define B2DA_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("b2da check failed");

// condition must hold after the trigger, at the delay given by dly
`define B2DA_ASSERT_LATER(label, clk, rst_n, trig, dly, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> ##dly (cond)) \
        else $error("b2da latency check failed");

`endif

@@ design/b2da_pkg.sv @@
// shared constants, types and helpers for the binary to decimal ascii converter
// no dependencies
package b2da_pkg;

    localparam int BIN_W      = 32;
    localparam int DIGITS     = 10;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int CHAR_W     = 6;
    localparam int LATENCY    = BIN_W + 1;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef logic [3:0]        digit_t;
    typedef logic [BIN_W-1:0]  bin_t;
    typedef logic [BCD_W-1:0]  bcd_t;
    typedef logic [CHAR_W-1:0] char_t;

    // one stage of the conversion chain
    typedef struct packed {
        logic valid;
        bin_t bin;
        bcd_t bcd;
    } stage_t;

    // add three to a digit of five or more, ahead of the doubling shift
    function automatic digit_t dabble(input digit_t d);
        digit_t r;
        r = d;
        if (d inside {[4'd5:4'd15]})
        begin
            r = d + 4'd3;
        end
        return r;
    endfunction

endpackage

@@ design/binary_to_decimal_ascii.sv @@
// top level of the binary to decimal ascii converter
// depends on b2da_pkg, b2da_cell, b2da_encode and binary_to_decimal_ascii_defines.svh

// Converts an unsigned 32-bit value into ten ascii decimal characters, most
// significant first, leading zeros kept. A transfer is taken at every clock
// edge with start high (busy is always low), so a new value may follow in the
// very next cycle. The value passes through 33 registers: 32 double-dabble
// cells, one per input bit, then one output register. The first of these loads
// at the edge that takes the transfer; the value moves on through the later
// cells, and the output register's load puts the result on the ports. done is
// high for exactly one cycle with char_0..char_9; the receiver cannot stall
// and must take the result in that cycle. Results come out in input order.
module binary_to_decimal_ascii (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [31:0]           value,
    output logic                  done,
    output logic [5:0]            char_0,
    output logic [5:0]            char_1,
    output logic [5:0]            char_2,
    output logic [5:0]            char_3,
    output logic [5:0]            char_4,
    output logic [5:0]            char_5,
    output logic [5:0]            char_6,
    output logic [5:0]            char_7,
    output logic [5:0]            char_8,
    output logic [5:0]            char_9
);
    import b2da_pkg::*;

    `include "binary_to_decimal_ascii_defines.svh"

    // links between neighbouring cells; link[0] is the incoming transfer
    stage_t link [BIN_W+1];
    char_t  chars [DIGITS];
    logic   accept;

    // the chain never blocks, so a transfer is taken whenever start is high
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // digits start at zero and the binary bits are shifted in msb first
    assign link[0] = '{valid: accept, bin: value, bcd: '0};

    // one cell per input bit
    for (genvar g = 0; g < BIN_W; g++)
    begin : g_cell
        b2da_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (link[g]),
            .stage_out (link[g+1])
        );
    end

    // ascii encoding and the result strobe
    b2da_encode u_encode (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (link[BIN_W]),
        .done     (done),
        .chars    (chars)
    );

    assign char_0 = chars[0];
    assign char_1 = chars[1];
    assign char_2 = chars[2];
    assign char_3 = chars[3];
    assign char_4 = chars[4];
    assign char_5 = chars[5];
    assign char_6 = chars[6];
    assign char_7 = chars[7];
    assign char_8 = chars[8];
    assign char_9 = chars[9];

    // every transfer yields a result after the fixed latency
    `B2DA_ASSERT_LATER(a_latency, clk, rst_n, accept, LATENCY, done)
    // no result without a matching transfer
    `B2DA_ASSERT_NOW(a_no_phantom, clk, rst_n, done, $past(accept, LATENCY))
    // leading digit of a 32-bit value is at most four
    `B2DA_ASSERT_NOW(a_top_digit, clk, rst_n, done, (char_0 >= 6'd48) && (char_0 <= 6'd52))
    // the units digit stays a decimal digit
    `B2DA_ASSERT_NOW(a_units_digit, clk, rst_n, done, (char_9 >= 6'd48) && (char_9 <= 6'd57))

endmodule

@@ design/b2da_cell.sv @@
// one double-dabble cell: corrects the digits and shifts in one binary bit
// depends on b2da_pkg
module b2da_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  b2da_pkg::stage_t stage_in,
    output b2da_pkg::stage_t stage_out
);
    import b2da_pkg::*;

    logic valid_reg;
    logic valid_next;
    bin_t bin_reg;
    bin_t bin_next;
    bcd_t bcd_reg;
    bcd_t bcd_next;
    bcd_t bcd_adj;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = dabble(stage_in.bcd[4*i +: 4]);
        end
        bcd_next   = {bcd_adj[BCD_W-2:0], stage_in.bin[BIN_W-1]};
        bin_next   = {stage_in.bin[BIN_W-2:0], 1'b0};
        valid_next = stage_in.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stage_out = '{valid: valid_reg, bin: bin_reg, bcd: bcd_reg};

endmodule

@@ design/b2da_encode.sv @@
// output register: turns the finished bcd digits into ascii characters
// depends on b2da_pkg
module b2da_encode (
    input  logic             clk,
    input  logic             rst_n,
    input  b2da_pkg::stage_t stage_in,
    output logic             done,
    output b2da_pkg::char_t  chars [b2da_pkg::DIGITS]
);
    import b2da_pkg::*;

    logic  done_reg;
    logic  done_next;
    char_t chars_reg  [DIGITS];
    char_t chars_next [DIGITS];

    always_comb
    begin
        done_next = stage_in.valid;
        // most significant digit first
        for (int i = 0; i < DIGITS; i++)
        begin
            chars_next[i] = {2'b00, stage_in.bcd[BCD_W-1-4*i -: 4]} + ASCII_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
    end

    assign done  = done_reg;
    assign chars = chars_reg;

endmodule

@@ test/binary_to_decimal_ascii_tb.sv @@
// self-checking testbench for the binary to decimal ascii converter
// depends on b2da_pkg and the binary_to_decimal_ascii top level
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;
    import b2da_pkg::*;

    // ten characters, index 0 is char_0 (most significant digit)
    typedef logic [DIGITS-1:0][CHAR_W-1:0] ascii_row_t;

    // one outstanding conversion: the operand and its decimal characters
    typedef struct packed {
        bin_t       operand;
        ascii_row_t chars;
    } conversion_t;

    localparam bin_t RADIX          = 10;
    localparam int   IDLE_PERCENT   = 16;
    localparam int   RANDOM_ITEMS   = 1650;
    localparam int   STALL_LIMIT    = 600;
    // transfers in this window are driven back to back, with no idle cycles
    localparam int   BURST_FIRST    = 700;
    localparam int   BURST_LAST     = 1000;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    bin_t       value = '0;
    logic       busy;
    logic       done;
    char_t      char_0, char_1, char_2, char_3, char_4;
    char_t      char_5, char_6, char_7, char_8, char_9;

    bin_t        operand_queue[$];
    conversion_t conversion_queue[$];
    int          operand_total    = 0;
    int          directed_total   = 0;
    int          transfer_count   = 0;
    int          result_count     = 0;
    int          fail_count       = 0;
    int          stall_cycles     = 0;

    binary_to_decimal_ascii dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .value  (value),
        .done   (done),
        .char_0 (char_0),
        .char_1 (char_1),
        .char_2 (char_2),
        .char_3 (char_3),
        .char_4 (char_4),
        .char_5 (char_5),
        .char_6 (char_6),
        .char_7 (char_7),
        .char_8 (char_8),
        .char_9 (char_9)
    );

    always #4 clk = ~clk;

    // ten to the power k, wide enough for k up to ten
    function automatic longint power_of_ten(input int k);
        longint p;
        p = 1;
        for (int i = 0; i < k; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    // decimal characters of an operand: peel off the units digit, shift right one place,
    // fill from the least significant end; leading zeros stay as '0'
    function automatic ascii_row_t decimal_chars(input bin_t operand);
        ascii_row_t row;
        bin_t       remaining;
        bin_t       digit;
        remaining = operand;
        for (int pos = DIGITS - 1; pos >= 0; pos--)
        begin
            digit     = remaining % RADIX;
            remaining = remaining / RADIX;
            // six-bit sum wraps just as the character port does
            row[pos]  = ASCII_ZERO + char_t'(digit);
        end
        return row;
    endfunction

    // driver: offers queued operands, holds them while busy, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            value <= '0;
        end
        else
        begin
            // a transfer is taken on this edge: record what must come back
            if (start && !busy)
            begin
                conversion_queue.push_back('{operand: value, chars: decimal_chars(value)});
                transfer_count++;
            end
            // the offer may change only once the current one is gone or was never made
            if (!start || !busy)
            begin
                if (operand_queue.size() > 0 &&
                    ((transfer_count >= BURST_FIRST && transfer_count < BURST_LAST) ||
                     $urandom_range(99) >= IDLE_PERCENT))
                begin
                    start <= 1'b1;
                    value <= operand_queue.pop_front();
                end
                else
                begin
                    // idle cycle: junk on the operand must be ignored
                    start <= 1'b0;
                    value <= $urandom;
                end
            end
        end
    end

    // monitor: every strobe must match the oldest outstanding conversion
    always @(posedge clk)
    begin
        conversion_t wanted;
        ascii_row_t  seen;
        if (rst_n && done)
        begin
            seen = {char_9, char_8, char_7, char_6, char_5,
                    char_4, char_3, char_2, char_1, char_0};
            if (conversion_queue.size() == 0)
            begin
                $error("result with no transfer outstanding: %s", seen);
                fail_count++;
            end
            else
            begin
                wanted = conversion_queue.pop_front();
                result_count++;
                for (int i = 0; i < DIGITS; i++)
                begin
                    if (seen[i] !== wanted.chars[i])
                    begin
                        $error("char_%0d of %0d: expected %0d, actual %0d",
                               i, wanted.operand, wanted.chars[i], seen[i]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog: too long without any transfer in or result out ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", stall_cycles);
                $display("FAIL binary_to_decimal_ascii");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        longint pattern;
        int     k;
        // directed: both ends of the range, each power of ten from ten up and the value just
        // below it (digit rollover in every place), and alternating bit patterns
        operand_queue.push_back(32'd0);
        operand_queue.push_back(32'hFFFF_FFFF);
        operand_queue.push_back(32'hFFFF_FFFE);
        for (k = 1; k <= 9; k++)
        begin
            operand_queue.push_back(bin_t'(power_of_ten(k)));
            operand_queue.push_back(bin_t'(power_of_ten(k) - 1));
        end
        operand_queue.push_back(32'h8000_0000);
        operand_queue.push_back(32'h5555_5555);
        operand_queue.push_back(32'hAAAA_AAAA);
        operand_queue.push_back(32'd4000000000);
        directed_total = operand_queue.size();

        // random: full-range words, short numbers, values close to a power of
        // ten, and numbers whose lower nine digits are each a nine or a zero, to stress the carries
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(3))
                0: operand_queue.push_back(bin_t'($urandom_range(999)));
                1:
                begin
                    k = $urandom_range(1, 9);
                    operand_queue.push_back(bin_t'(power_of_ten(k) +
                                                   longint'($urandom_range(6)) - 3));
                end
                2:
                begin
                    pattern = $urandom_range(3);
                    for (k = 0; k < DIGITS - 1; k++)
                    begin
                        pattern = pattern * 10 + ($urandom_range(1) ? 9 : 0);
                    end
                    operand_queue.push_back(bin_t'(pattern));
                end
                default: operand_queue.push_back(bin_t'($urandom));
            endcase
        end
        operand_total = operand_queue.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything sent and every result back, then watch for strays
        while (transfer_count < operand_total || conversion_queue.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 8) @(posedge clk);

        $display("%0d operands converted (%0d directed), %0d results compared",
                 transfer_count, directed_total, result_count);
        if (fail_count == 0)
        begin
            $display("PASS binary_to_decimal_ascii");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("FAIL binary_to_decimal_ascii");
        end
        $finish;
    end

endmodule
